### sv/ctc_pkg.sv
// ----------------------------------------------------------------------------
// ctc_pkg
// Shared widths, types, register codes and the tetrahedron table of the cube
// connectivity block.
// ----------------------------------------------------------------------------
package ctc_pkg;

   localparam int COORD_W       = 8;
   localparam int COUNT_W       = 9;
   localparam int LINE_W        = COUNT_W + 1;
   localparam int NODE_W        = 27;
   localparam int TET_W         = 5;
   localparam int SEL_W         = 3;
   localparam int CSR_IDX_W     = 2;
   localparam int TETS_PER_CUBE = 24;
   localparam int NUM_FACES     = 6;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [TET_W-1:0] LAST_TET = TET_W'(TETS_PER_CUBE - 1);

   typedef logic [NODE_W-1:0]  node_type;
   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [LINE_W-1:0]  line_type;
   typedef logic [TET_W-1:0]   tet_type;
   typedef logic [SEL_W-1:0]   sel_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BLOCKS_X = 2'd0,
      REG_BLOCKS_Y = 2'd1,
      REG_BLOCKS_Z = 2'd2
   } csr_reg_type;

   // faces: z-low, x-high, z-high, x-low, y-low, y-high
   typedef struct packed {
      logic                       bad;
      node_type                   corner0;
      line_type                   line;
      node_type                   slice;
      node_type [NUM_FACES-1:0]   face;
      node_type                   body;
   } cube_rec_type;

   typedef struct packed {
      sel_type face_sel;
      sel_type corner_a;
      sel_type corner_b;
   } tet_entry_type;

   function automatic tet_entry_type tet_entry(input tet_type t);
      tet_entry_type e;
      unique case (t)
         5'd0:  e = '{3'd0, 3'd0, 3'd1};
         5'd1:  e = '{3'd0, 3'd1, 3'd3};
         5'd2:  e = '{3'd0, 3'd3, 3'd2};
         5'd3:  e = '{3'd0, 3'd2, 3'd0};
         5'd4:  e = '{3'd1, 3'd1, 3'd5};
         5'd5:  e = '{3'd1, 3'd5, 3'd7};
         5'd6:  e = '{3'd1, 3'd7, 3'd3};
         5'd7:  e = '{3'd1, 3'd3, 3'd1};
         5'd8:  e = '{3'd2, 3'd5, 3'd4};
         5'd9:  e = '{3'd2, 3'd4, 3'd6};
         5'd10: e = '{3'd2, 3'd6, 3'd7};
         5'd11: e = '{3'd2, 3'd7, 3'd5};
         5'd12: e = '{3'd3, 3'd4, 3'd0};
         5'd13: e = '{3'd3, 3'd0, 3'd2};
         5'd14: e = '{3'd3, 3'd2, 3'd6};
         5'd15: e = '{3'd3, 3'd6, 3'd4};
         5'd16: e = '{3'd4, 3'd1, 3'd0};
         5'd17: e = '{3'd4, 3'd0, 3'd4};
         5'd18: e = '{3'd4, 3'd4, 3'd5};
         5'd19: e = '{3'd4, 3'd5, 3'd1};
         5'd20: e = '{3'd5, 3'd2, 3'd3};
         5'd21: e = '{3'd5, 3'd3, 3'd7};
         5'd22: e = '{3'd5, 3'd7, 3'd6};
         5'd23: e = '{3'd5, 3'd6, 3'd2};
         default: e = '0;
      endcase
      return e;
   endfunction

endpackage

### sv/ctc_if.sv
// ----------------------------------------------------------------------------
// ctc_if
// Valid/ready channels of the cube connectivity block: cube requests,
// tetrahedron responses and register writes.
// ----------------------------------------------------------------------------
interface ctc_req_if;
   logic                valid;
   logic                ready;
   ctc_pkg::coord_type  cube_x;
   ctc_pkg::coord_type  cube_y;
   ctc_pkg::coord_type  cube_z;

   modport source (output valid, output cube_x, output cube_y, output cube_z, input ready);
   modport sink   (input valid, input cube_x, input cube_y, input cube_z, output ready);
endinterface

interface ctc_rsp_if;
   logic                valid;
   logic                ready;
   ctc_pkg::tet_type    tet_number;
   ctc_pkg::node_type   node_body;
   ctc_pkg::node_type   node_face;
   ctc_pkg::node_type   node_corner_a;
   ctc_pkg::node_type   node_corner_b;
   logic                last_tet;
   logic                bad_cube;

   modport source (output valid, output tet_number, output node_body, output node_face,
                   output node_corner_a, output node_corner_b, output last_tet,
                   output bad_cube, input ready);
   modport sink   (input valid, input tet_number, input node_body, input node_face,
                   input node_corner_a, input node_corner_b, input last_tet,
                   input bad_cube, output ready);
endinterface

interface ctc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [ctc_pkg::CSR_IDX_W-1:0]    index;
   ctc_pkg::count_type               data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/ctc_front.sv
// ----------------------------------------------------------------------------
// ctc_front
// Holds the grid registers, takes one cube, checks it against the grid and
// works out its corner base, face and body node numbers over a few steps.
// ----------------------------------------------------------------------------
module ctc_front #(
   parameter int MAX_BLOCKS = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   ctc_req_if.sink               req_bus,
   ctc_csr_if.sink               csr_bus,
   output logic                  push_valid,
   input  logic                  push_ready,
   output ctc_pkg::cube_rec_type push_data
);

   typedef enum logic [9:0] {
      F_IDLE = 10'b00_0000_0001,
      F_MUL1 = 10'b00_0000_0010,
      F_MUL2 = 10'b00_0000_0100,
      F_MUL3 = 10'b00_0000_1000,
      F_MUL4 = 10'b00_0001_0000,
      F_MUL5 = 10'b00_0010_0000,
      F_SUM1 = 10'b00_0100_0000,
      F_SUM2 = 10'b00_1000_0000,
      F_SUM3 = 10'b01_0000_0000,
      F_PUSH = 10'b10_0000_0000
   } front_state_type;

   function automatic ctc_pkg::count_type sat_count(input ctc_pkg::count_type v);
      if (int'(v) > MAX_BLOCKS) begin
         return ctc_pkg::count_type'(MAX_BLOCKS);
      end
      return v;
   endfunction

   front_state_type        state_ff, state_in;
   ctc_pkg::count_type     blocks_x_ff, blocks_y_ff, blocks_z_ff;
   ctc_pkg::count_type     sat_x, sat_y, sat_z;
   logic                   accept, bad;

   ctc_pkg::coord_type     cx_ff, cy_ff, cz_ff;
   ctc_pkg::count_type     bx_ff, by_ff, bz_ff;
   ctc_pkg::line_type      line, by1, bz1;
   ctc_pkg::node_type      slice_ff, bxby_ff, jline_ff, jbx_ff, kby_ff, kbx_ff;
   ctc_pkg::node_type      basezf_ff, zfcnt_ff, xfcnt_ff, yfcnt_ff, kslice_ff, kbxby_ff;
   ctc_pkg::node_type      corner0_ff, center_ff, basexf_ff, xy_ff;
   ctc_pkg::node_type      czf_ff, cxf_ff, cyf_ff, cbd_ff;
   ctc_pkg::cube_rec_type  rec_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         blocks_x_ff <= ctc_pkg::count_type'(1);
         blocks_y_ff <= ctc_pkg::count_type'(1);
         blocks_z_ff <= ctc_pkg::count_type'(1);
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            ctc_pkg::REG_BLOCKS_X: blocks_x_ff <= csr_bus.data;
            ctc_pkg::REG_BLOCKS_Y: blocks_y_ff <= csr_bus.data;
            ctc_pkg::REG_BLOCKS_Z: blocks_z_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      sat_x  = sat_count(blocks_x_ff);
      sat_y  = sat_count(blocks_y_ff);
      sat_z  = sat_count(blocks_z_ff);
      bad    = ({1'b0, req_bus.cube_x} >= sat_x) || ({1'b0, req_bus.cube_y} >= sat_y) ||
               ({1'b0, req_bus.cube_z} >= sat_z);
      accept = req_bus.valid && req_bus.ready;
      line   = {1'b0, bx_ff} + ctc_pkg::line_type'(1);
      by1    = {1'b0, by_ff} + ctc_pkg::line_type'(1);
      bz1    = {1'b0, bz_ff} + ctc_pkg::line_type'(1);
   end

   assign req_bus.ready = (state_ff == F_IDLE);
   assign push_valid    = (state_ff == F_PUSH);
   assign push_data     = rec_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: if (accept) state_in = bad ? F_PUSH : F_MUL1;
         F_MUL1: state_in = F_MUL2;
         F_MUL2: state_in = F_MUL3;
         F_MUL3: state_in = F_MUL4;
         F_MUL4: state_in = F_MUL5;
         F_MUL5: state_in = F_SUM1;
         F_SUM1: state_in = F_SUM2;
         F_SUM2: state_in = F_SUM3;
         F_SUM3: state_in = F_PUSH;
         F_PUSH: if (push_ready) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               cx_ff <= req_bus.cube_x;
               cy_ff <= req_bus.cube_y;
               cz_ff <= req_bus.cube_z;
               bx_ff <= sat_x;
               by_ff <= sat_y;
               bz_ff <= sat_z;
               rec_ff <= ctc_pkg::cube_rec_type'(
                            {bad, {($bits(ctc_pkg::cube_rec_type) - 1){1'b0}}});
            end
         end
         F_MUL1: begin
            slice_ff <= ctc_pkg::node_type'(line) * ctc_pkg::node_type'(by1);
            bxby_ff  <= ctc_pkg::node_type'(bx_ff) * ctc_pkg::node_type'(by_ff);
            jline_ff <= ctc_pkg::node_type'(cy_ff) * ctc_pkg::node_type'(line);
         end
         F_MUL2: begin
            jbx_ff <= ctc_pkg::node_type'(cy_ff) * ctc_pkg::node_type'(bx_ff);
            kby_ff <= ctc_pkg::node_type'(cz_ff) * ctc_pkg::node_type'(by_ff);
            kbx_ff <= ctc_pkg::node_type'(cz_ff) * ctc_pkg::node_type'(bx_ff);
         end
         F_MUL3: begin
            basezf_ff <= slice_ff * ctc_pkg::node_type'(bz1);
            zfcnt_ff  <= bxby_ff * ctc_pkg::node_type'(bz1);
         end
         F_MUL4: begin
            xfcnt_ff <= ctc_pkg::node_type'(bz_ff) * (slice_ff - ctc_pkg::node_type'(line));
            yfcnt_ff <= ctc_pkg::node_type'(bz_ff) * (bxby_ff + ctc_pkg::node_type'(bx_ff));
         end
         F_MUL5: begin
            kslice_ff <= ctc_pkg::node_type'(cz_ff) * slice_ff;
            kbxby_ff  <= ctc_pkg::node_type'(cz_ff) * bxby_ff;
         end
         F_SUM1: begin
            corner0_ff <= ctc_pkg::node_type'(cx_ff) + jline_ff + kslice_ff;
            center_ff  <= ctc_pkg::node_type'(cx_ff) + jbx_ff + kbxby_ff;
            basexf_ff  <= basezf_ff + zfcnt_ff;
            xy_ff      <= xfcnt_ff + yfcnt_ff;
         end
         F_SUM2: begin
            czf_ff <= basezf_ff + center_ff;
            cxf_ff <= basexf_ff + center_ff + ctc_pkg::node_type'(cy_ff) + kby_ff;
            cyf_ff <= basexf_ff + xfcnt_ff + center_ff + kbx_ff;
            cbd_ff <= basexf_ff + xy_ff + center_ff;
         end
         F_SUM3: begin
            rec_ff.bad     <= 1'b0;
            rec_ff.corner0 <= corner0_ff;
            rec_ff.line    <= line;
            rec_ff.slice   <= slice_ff;
            rec_ff.face[0] <= czf_ff;
            rec_ff.face[1] <= cxf_ff + ctc_pkg::node_type'(1);
            rec_ff.face[2] <= czf_ff + bxby_ff;
            rec_ff.face[3] <= cxf_ff;
            rec_ff.face[4] <= cyf_ff;
            rec_ff.face[5] <= cyf_ff + ctc_pkg::node_type'(bx_ff);
            rec_ff.body    <= cbd_ff;
         end
         F_PUSH: ;
         default: ;
      endcase
   end

endmodule

### sv/ctc_queue.sv
// ----------------------------------------------------------------------------
// ctc_queue
// Short queue of prepared cube records between the front and back parts.
// ----------------------------------------------------------------------------
module ctc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  ctc_pkg::cube_rec_type push_data,
   output logic                  head_valid,
   output ctc_pkg::cube_rec_type head_data,
   input  logic                  pop
);

   localparam int PTR_W = (ctc_pkg::QUEUE_DEPTH > 1) ? $clog2(ctc_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(ctc_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(ctc_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ctc_pkg::QUEUE_DEPTH);

   ctc_pkg::cube_rec_type entries_ff [ctc_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_data  = entries_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push_valid && push_ready;
      do_pop    = pop && head_valid;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ptr_ff] <= push_data;
   end

endmodule

### sv/ctc_back.sv
// ----------------------------------------------------------------------------
// ctc_back
// Walks the 24 tetrahedra of the cube at the queue head, or gives a single item
// for a bad cube, and drives the response register.
// ----------------------------------------------------------------------------
module ctc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  ctc_pkg::cube_rec_type head_data,
   output logic                  pop,
   ctc_rsp_if.source             rsp_bus
);

   function automatic ctc_pkg::node_type corner_node(input ctc_pkg::cube_rec_type r,
                                                     input ctc_pkg::sel_type sel);
      ctc_pkg::node_type n;
      n = r.corner0 + ctc_pkg::node_type'(sel[0]);
      if (sel[1]) n = n + ctc_pkg::node_type'(r.line);
      if (sel[2]) n = n + r.slice;
      return n;
   endfunction

   ctc_pkg::tet_type       tet_cnt_ff, tet_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   ctc_pkg::tet_type       tet_ff;
   ctc_pkg::node_type      body_ff, face_ff, corner_a_ff, corner_b_ff;
   logic                   last_ff, bad_ff;
   ctc_pkg::tet_entry_type ent;
   logic                   is_last, out_free, load;

   always_comb begin
      ent          = ctc_pkg::tet_entry(tet_cnt_ff);
      is_last      = (tet_cnt_ff == ctc_pkg::LAST_TET);
      out_free     = !rsp_valid_ff || rsp_bus.ready;
      load         = out_free && head_valid;
      pop          = load && (head_data.bad || is_last);
      rsp_valid_in = load || (rsp_valid_ff && !rsp_bus.ready);
      tet_cnt_in   = tet_cnt_ff;
      if (load && !head_data.bad) begin
         tet_cnt_in = is_last ? '0 : tet_cnt_ff + ctc_pkg::tet_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         tet_cnt_ff   <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         tet_cnt_ff   <= tet_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         if (head_data.bad) begin
            tet_ff      <= '0;
            body_ff     <= '0;
            face_ff     <= '0;
            corner_a_ff <= '0;
            corner_b_ff <= '0;
            last_ff     <= 1'b1;
            bad_ff      <= 1'b1;
         end else begin
            tet_ff      <= tet_cnt_ff;
            body_ff     <= head_data.body;
            face_ff     <= head_data.face[ent.face_sel];
            corner_a_ff <= corner_node(head_data, ent.corner_a);
            corner_b_ff <= corner_node(head_data, ent.corner_b);
            last_ff     <= is_last;
            bad_ff      <= 1'b0;
         end
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.tet_number    = tet_ff;
   assign rsp_bus.node_body     = body_ff;
   assign rsp_bus.node_face     = face_ff;
   assign rsp_bus.node_corner_a = corner_a_ff;
   assign rsp_bus.node_corner_b = corner_b_ff;
   assign rsp_bus.last_tet      = last_ff;
   assign rsp_bus.bad_cube      = bad_ff;

endmodule

### sv/cube_tetrahedra_connectivity.sv
// ----------------------------------------------------------------------------
// cube_tetrahedra_connectivity
// Splits one grid cube into 24 tetrahedra and emits their global node numbers.
// ----------------------------------------------------------------------------
// Channels: req_bus takes one cube coordinate per item; rsp_bus returns the
// 24 tetrahedra of that cube in fixed order (body center, face center, two
// corners), last_tet marking the final one. A cube outside the grid returns
// a single item with bad_cube and last_tet set and all numbers zero.
// csr_bus writes the block counts (index 0..2 for x, y, z; others ignored);
// write only while no cube is in flight.
// Sequence: a cube passes the front sequencer (five multiply steps, three add
// steps, push) and the queue before its first tetrahedron leaves the
// response register. Throughput: one tetrahedron per cycle while rsp_bus.ready
// is high; the back part's tetrahedron counter walks the 24 tetrahedra of
// each cube, and the front prepares the next cube meanwhile. A bad cube
// goes straight from accept to push in the front and yields one response item.
// Reset: block counts return to 1, queue and response register empty.
// Stall: the response register holds while rsp_bus.ready is low; the
// two-entry queue then fills and req_bus.ready drops.
// ----------------------------------------------------------------------------
module cube_tetrahedra_connectivity #(
   parameter int MAX_BLOCKS = 256
) (
   input  logic       clock,
   input  logic       reset,
   ctc_req_if.sink    req_bus,
   ctc_rsp_if.source  rsp_bus,
   ctc_csr_if.sink    csr_bus
);

   logic                  push_valid, push_ready, head_valid, pop;
   ctc_pkg::cube_rec_type push_data, head_data;

   ctc_front #(.MAX_BLOCKS(MAX_BLOCKS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   ctc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop)
   );

   ctc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

### sv/ctc_checker.sv
// ----------------------------------------------------------------------------
// ctc_checker
// Port-level checks of the response sequence of the cube connectivity block.
// ----------------------------------------------------------------------------
module ctc_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ctc_pkg::tet_type  rsp_tet_number,
   input ctc_pkg::node_type rsp_node_body,
   input ctc_pkg::node_type rsp_node_face,
   input ctc_pkg::node_type rsp_node_corner_a,
   input ctc_pkg::node_type rsp_node_corner_b,
   input logic              rsp_last_tet,
   input logic              rsp_bad_cube
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
      $stable({rsp_tet_number, rsp_node_body, rsp_node_face, rsp_node_corner_a,
               rsp_node_corner_b, rsp_last_tet, rsp_bad_cube}))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_bad_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_cube |-> rsp_last_tet && rsp_tet_number == '0 &&
      rsp_node_body == '0 && rsp_node_face == '0 &&
      rsp_node_corner_a == '0 && rsp_node_corner_b == '0)
      else $error("bad cube item not cleared");

   a_last_mark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bad_cube |-> rsp_last_tet == (rsp_tet_number == ctc_pkg::LAST_TET))
      else $error("last tetrahedron mark wrong");

   a_next_tet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_tet |=>
      rsp_valid && rsp_tet_number == $past(rsp_tet_number) + ctc_pkg::tet_type'(1))
      else $error("tetrahedron sequence broken");

endmodule

bind cube_tetrahedra_connectivity ctc_checker u_ctc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_tet_number    (rsp_bus.tet_number),
   .rsp_node_body     (rsp_bus.node_body),
   .rsp_node_face     (rsp_bus.node_face),
   .rsp_node_corner_a (rsp_bus.node_corner_a),
   .rsp_node_corner_b (rsp_bus.node_corner_b),
   .rsp_last_tet      (rsp_bus.last_tet),
   .rsp_bad_cube      (rsp_bus.bad_cube)
);
